[hw/rtl/pnf_pkg.sv]
package pnf_pkg;

  localparam int MaxWidthDef   = 64;
  localparam int DigitSlotsDef = 16;

  // field width counters; holds MAX_WIDTH and the longest content
  localparam int CntW = 7;
  localparam int ValW = 32;

  localparam logic [2:0] ActSdec = 3'd0;
  localparam logic [2:0] ActUdec = 3'd1;
  localparam logic [2:0] ActHex  = 3'd2;
  localparam logic [2:0] ActOct  = 3'd3;
  localparam logic [2:0] ActChar = 3'd4;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharX     = 8'h78;

  // ceil(2^35 / 10): q = (x * RecipTen) >> 35 is exact for 32-bit x
  localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    ContNone = 2'd0,
    ContNum  = 2'd1,
    ContChar = 2'd2
  } cont_e;

  typedef enum logic [1:0] {
    RadixDec = 2'd0,
    RadixHex = 2'd1,
    RadixOct = 2'd2
  } radix_e;

  typedef struct packed {
    cont_e             cont;
    radix_e            radix;
    logic [ValW-1:0]   mag;
    logic [7:0]        pre0;
    logic [7:0]        pre1;
    logic [1:0]        npre;
    logic              left;
    logic              zero;
    logic [CntW-1:0]   w;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

endpackage

[hw/rtl/pnf_front.sv]
module pnf_front
  import pnf_pkg::*;
#(
  parameter int MaxWidth = MaxWidthDef
) (
  input  logic            start,
  input  logic [2:0]      action_i,
  input  logic [ValW-1:0] value_i,
  input  logic            flag_left_i,
  input  logic            flag_sign_i,
  input  logic            flag_space_i,
  input  logic            flag_prefix_i,
  input  logic            flag_zero_i,
  input  logic [CntW-1:0] width_i,
  input  logic            q_full_i,
  output q_ctl_t          q_ctl_o,
  output job_t            job_o
);

  always_comb begin
    job_o       = '0;
    job_o.cont  = ContNone;
    job_o.radix = RadixDec;
    job_o.mag   = value_i;
    job_o.pre0  = CharSpace;
    job_o.pre1  = CharSpace;
    job_o.npre  = 2'd0;
    job_o.left  = flag_left_i;
    job_o.zero  = flag_zero_i & ~flag_left_i;
    job_o.w     = (width_i > CntW'(MaxWidth)) ? CntW'(MaxWidth) : width_i;
    unique case (action_i)
      ActSdec: begin
        job_o.cont = ContNum;
        if (value_i[ValW-1]) begin
          job_o.mag  = ~value_i + ValW'(1);
          job_o.pre0 = CharMinus;
          job_o.npre = 2'd1;
        end else if (flag_sign_i) begin
          job_o.pre0 = CharPlus;
          job_o.npre = 2'd1;
        end else if (flag_space_i) begin
          job_o.pre0 = CharSpace;
          job_o.npre = 2'd1;
        end
      end
      ActUdec: begin
        job_o.cont = ContNum;
      end
      ActHex: begin
        job_o.cont  = ContNum;
        job_o.radix = RadixHex;
        if (flag_prefix_i) begin
          job_o.pre0 = CharZero;
          job_o.pre1 = CharX;
          job_o.npre = 2'd2;
        end
      end
      ActOct: begin
        job_o.cont  = ContNum;
        job_o.radix = RadixOct;
        if (flag_prefix_i) begin
          job_o.pre0 = CharZero;
          job_o.npre = 2'd1;
        end
      end
      ActChar: begin
        job_o.cont = ContChar;
      end
      default: begin
        job_o.cont = ContNone;
      end
    endcase
  end

  assign q_ctl_o.push = start & ~q_full_i;
  assign q_ctl_o.full = q_full_i;

endmodule

[hw/rtl/pnf_queue.sv]
module pnf_queue
  import pnf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_ctl_t     q_ctl_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output logic [1:0] count_o,
  output job_t       job_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign count_o = cnt_q;
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ q_ctl_i.push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, q_ctl_i.push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_ctl_i.push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[hw/rtl/pnf_back.sv]
module pnf_back
  import pnf_pkg::*;
#(
  parameter int DigitSlots = DigitSlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       strobe_o,
  output logic [7:0] char_out_o,
  output logic       last_o
);

  localparam int DigIdxW = $clog2(DigitSlots);
  localparam int NdW     = $clog2(DigitSlots + 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StConv  = 4'b0010,
    StSetup = 4'b0100,
    StEmit  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  job_t            job_q;
  logic [ValW-1:0] mag_q;
  logic [NdW-1:0]  nd_q;
  logic [7:0]      dig_q [DigitSlots];
  logic [CntW-1:0] lead_end_q, pre_end_q, zero_end_q, dig_end_q, total_q, pos_q;
  logic            strobe_q, last_q;
  logic [7:0]      char_q;

  // digit step
  logic [63:0]     prod;
  logic [ValW-1:0] quot_dec, quot;
  logic [ValW-1:0] rem_dec;
  logic [3:0]      dval;
  logic [7:0]      dchar;
  logic            conv_done;

  // field layout
  logic [CntW-1:0] len, pad, lead_end, pre_end, zero_end, dig_end, total;

  // emission select
  logic [CntW-1:0]    dsub, psub;
  logic [DigIdxW-1:0] didx;
  logic [7:0]         ch;

  always_comb begin
    prod     = {32'd0, mag_q} * {32'd0, RecipTen};
    quot_dec = {3'd0, prod[63:35]};
    rem_dec  = mag_q - ((quot_dec << 3) + (quot_dec << 1));
    unique case (job_q.radix)
      RadixHex: begin
        quot = mag_q >> 4;
        dval = mag_q[3:0];
      end
      RadixOct: begin
        quot = mag_q >> 3;
        dval = {1'b0, mag_q[2:0]};
      end
      default: begin
        quot = quot_dec;
        dval = rem_dec[3:0];
      end
    endcase
    dchar     = (dval < 4'd10) ? (CharZero + {4'd0, dval})
                               : (CharA + {4'd0, dval} - 8'd10);
    conv_done = (quot == '0) || (nd_q == NdW'(DigitSlots - 1));
  end

  always_comb begin
    len      = CntW'(job_q.npre) + CntW'(nd_q);
    pad      = (job_q.w > len) ? (job_q.w - len) : '0;
    lead_end = (!job_q.left && !job_q.zero) ? pad : '0;
    pre_end  = lead_end + CntW'(job_q.npre);
    zero_end = pre_end + (job_q.zero ? pad : '0);
    dig_end  = zero_end + CntW'(nd_q);
    total    = dig_end + (job_q.left ? pad : '0);
  end

  always_comb begin
    dsub = dig_end_q - CntW'(1) - pos_q;
    didx = dsub[DigIdxW-1:0];
    psub = pos_q - lead_end_q;
    priority if (pos_q < lead_end_q) begin
      ch = CharSpace;
    end else if (pos_q < pre_end_q) begin
      ch = psub[0] ? job_q.pre1 : job_q.pre0;
    end else if (pos_q < zero_end_q) begin
      ch = CharZero;
    end else if (pos_q < dig_end_q) begin
      ch = dig_q[didx];
    end else begin
      ch = CharSpace;
    end
  end

  assign pop_o = (state_q == StIdle) && job_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          state_d = (job_i.cont == ContNum) ? StConv : StSetup;
        end
      end
      StConv: begin
        if (conv_done) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        state_d = (total == '0) ? StIdle : StEmit;
      end
      StEmit: begin
        if (pos_q == total_q - CntW'(1)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == StEmit);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        job_q <= job_i;
        mag_q <= job_i.mag;
        nd_q  <= '0;
        if (job_i.cont == ContChar) begin
          dig_q[0] <= job_i.mag[7:0];
          nd_q     <= NdW'(1);
        end
      end
      StConv: begin
        dig_q[nd_q[DigIdxW-1:0]] <= dchar;
        nd_q  <= nd_q + NdW'(1);
        mag_q <= quot;
      end
      StSetup: begin
        lead_end_q <= lead_end;
        pre_end_q  <= pre_end;
        zero_end_q <= zero_end;
        dig_end_q  <= dig_end;
        total_q    <= total;
        pos_q      <= '0;
      end
      StEmit: begin
        pos_q  <= pos_q + CntW'(1);
        char_q <= ch;
        last_q <= (pos_q == total_q - CntW'(1));
      end
      default: begin
        pos_q <= '0;
      end
    endcase
  end

  assign strobe_o   = strobe_q;
  assign char_out_o = char_q;
  assign last_o     = strobe_q & last_q;

endmodule

[hw/rtl/printf_number_formatter.sv]
// channel   dir  handshake               words
// command   in   start / busy            action, value, flags, width
// result    out  strobe_o, one cycle     char_out, last
//
// Per item the back end loads the job, converts one digit per cycle for the
// numeric kinds (at most 11 for 32 bits, none for a character or an undefined
// kind), computes the layout, then emits one output character per cycle,
// max(min(width, MaxWidth), content length) characters in all.
// A two-word queue sits between decode and the back end; busy is high
// while both queue slots are taken. Reset clears queue and sequencer.
// Results cannot be held off: each strobe lasts exactly one cycle.
module printf_number_formatter
  import pnf_pkg::*;
#(
  parameter int MaxWidth   = MaxWidthDef,
  parameter int DigitSlots = DigitSlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      action_i,
  input  logic [ValW-1:0] value_i,
  input  logic            flag_left_i,
  input  logic            flag_sign_i,
  input  logic            flag_space_i,
  input  logic            flag_prefix_i,
  input  logic            flag_zero_i,
  input  logic [CntW-1:0] width_i,
  output logic            strobe_o,
  output logic [7:0]      char_out_o,
  output logic            last_o
);

  q_ctl_t     q_ctl;
  job_t       job_in, job_out;
  logic       q_full, q_valid, pop;
  logic [1:0] q_count;

  pnf_front #(
    .MaxWidth(MaxWidth)
  ) u_front (
    .start        (start),
    .action_i     (action_i),
    .value_i      (value_i),
    .flag_left_i  (flag_left_i),
    .flag_sign_i  (flag_sign_i),
    .flag_space_i (flag_space_i),
    .flag_prefix_i(flag_prefix_i),
    .flag_zero_i  (flag_zero_i),
    .width_i      (width_i),
    .q_full_i     (q_full),
    .q_ctl_o      (q_ctl),
    .job_o        (job_in)
  );

  pnf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_ctl_i(q_ctl),
    .job_i  (job_in),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .count_o(q_count),
    .job_o  (job_out)
  );

  pnf_back #(
    .DigitSlots(DigitSlots)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (job_out),
    .pop_o      (pop),
    .strobe_o   (strobe_o),
    .char_out_o (char_out_o),
    .last_o     (last_o)
  );

  assign busy = q_ctl.full;

  // characters of one field come out without gaps
  a_field_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("gap inside a field");

  // after the final character the back end must reload before emitting
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("strobe right after last");

  // an accepted command is held in the queue on the next cycle
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> q_count != 2'd0)
    else $error("accepted word lost");

endmodule

[sim/pnf_field_checker.sv]
`timescale 1ns / 1ps

// Watches the command and result channels of the formatter, builds the
// expected characters of each accepted command word and compares every
// strobed character, in order, against them.
module pnf_field_checker
  import pnf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  logic [2:0]      action_i,
  input  logic [ValW-1:0] value_i,
  input  logic            flag_left_i,
  input  logic            flag_sign_i,
  input  logic            flag_space_i,
  input  logic            flag_prefix_i,
  input  logic            flag_zero_i,
  input  logic [CntW-1:0] width_i,
  input  logic            strobe_i,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int MaxWidth   = MaxWidthDef;
  localparam int DigitSlots = DigitSlotsDef;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  field_char_t field_chars_q[$];
  int          mismatch_cnt = 0;

  assign fail_count_o = mismatch_cnt;

  task automatic build_field(input logic [2:0] act, input logic [ValW-1:0] val,
                             input logic left, input logic sgn, input logic spc,
                             input logic pfx, input logic zro,
                             input logic [CntW-1:0] wid);
    logic [7:0]      pre [2];
    logic [7:0]      digs [DigitSlots];
    logic [ValW-1:0] mag;
    logic [ValW-1:0] radix;
    logic [ValW-1:0] rem;
    logic            zpad;
    int              npre;
    int              nd;
    int              len;
    int              pad;
    int              w;
    field_char_t     line_q[$];
    npre  = 0;
    nd    = 0;
    mag   = val;
    radix = 32'd10;
    zpad  = zro && !left;
    w     = (int'(wid) > MaxWidth) ? MaxWidth : int'(wid);
    if (act == ActSdec || act == ActUdec || act == ActHex || act == ActOct) begin
      if (act == ActSdec) begin
        if (val[ValW-1]) begin
          mag = ~val + 32'd1;
          pre[npre] = CharMinus;
          npre++;
        end else if (sgn) begin
          pre[npre] = CharPlus;
          npre++;
        end else if (spc) begin
          pre[npre] = CharSpace;
          npre++;
        end
      end else if (act == ActHex) begin
        radix = 32'd16;
        if (pfx) begin
          pre[0] = CharZero;
          pre[1] = CharX;
          npre = 2;
        end
      end else if (act == ActOct) begin
        radix = 32'd8;
        if (pfx) begin
          pre[0] = CharZero;
          npre = 1;
        end
      end
      // digits collected least significant first
      do begin
        rem = mag % radix;
        digs[nd] = (rem < 32'd10) ? CharZero + rem[7:0] : CharA + rem[7:0] - 8'd10;
        nd++;
        mag = mag / radix;
      end while (mag != 0 && nd < DigitSlots);
    end else if (act == ActChar) begin
      digs[0] = val[7:0];
      nd = 1;
    end
    len = npre + nd;
    pad = (w > len) ? w - len : 0;
    if (!left && !zpad)
      for (int i = 0; i < pad; i++) line_q.push_back('{CharSpace, 1'b0});
    for (int i = 0; i < npre; i++) line_q.push_back('{pre[i], 1'b0});
    if (zpad)
      for (int i = 0; i < pad; i++) line_q.push_back('{CharZero, 1'b0});
    for (int i = nd - 1; i >= 0; i--) line_q.push_back('{digs[i], 1'b0});
    if (left)
      for (int i = 0; i < pad; i++) line_q.push_back('{CharSpace, 1'b0});
    if (line_q.size() > 0) line_q[line_q.size() - 1].last = 1'b1;
    foreach (line_q[i]) field_chars_q.push_back(line_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    field_char_t want;
    if (!rst_ni) begin
      pending_o <= 0;
    end else begin
      if (strobe_i) begin
        if (field_chars_q.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, char_i, last_i);
          mismatch_cnt++;
        end else begin
          want = field_chars_q.pop_front();
          if (char_i !== want.ch) begin
            $display("%0t: char_out mismatch: expected %h, actual %h",
                     $time, want.ch, char_i);
            mismatch_cnt++;
          end
          if (last_i !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, last_i);
            mismatch_cnt++;
          end
        end
      end
      if (start_i && !busy_i)
        build_field(action_i, value_i, flag_left_i, flag_sign_i, flag_space_i,
                    flag_prefix_i, flag_zero_i, width_i);
      pending_o <= field_chars_q.size();
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import pnf_pkg::*;

  localparam int RandWords  = 370;
  localparam int TailCycles = 200;
  localparam int CycleLimit = 400000;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            start         = 1'b0;
  logic            busy;
  logic [2:0]      action_i      = '0;
  logic [ValW-1:0] value_i       = '0;
  logic            flag_left_i   = 1'b0;
  logic            flag_sign_i   = 1'b0;
  logic            flag_space_i  = 1'b0;
  logic            flag_prefix_i = 1'b0;
  logic            flag_zero_i   = 1'b0;
  logic [CntW-1:0] width_i       = '0;
  logic            strobe_o;
  logic [7:0]      char_out_o;
  logic            last_o;
  logic            busy_s        = 1'b0;
  int              fail_count;
  int              pending;
  int              cycle_cnt     = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // busy as seen at the coming rising edge
  always @(negedge clk_i) busy_s <= busy;

  printf_number_formatter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .value_i      (value_i),
    .flag_left_i  (flag_left_i),
    .flag_sign_i  (flag_sign_i),
    .flag_space_i (flag_space_i),
    .flag_prefix_i(flag_prefix_i),
    .flag_zero_i  (flag_zero_i),
    .width_i      (width_i),
    .strobe_o     (strobe_o),
    .char_out_o   (char_out_o),
    .last_o       (last_o)
  );

  pnf_field_checker u_fmt_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .action_i     (action_i),
    .value_i      (value_i),
    .flag_left_i  (flag_left_i),
    .flag_sign_i  (flag_sign_i),
    .flag_space_i (flag_space_i),
    .flag_prefix_i(flag_prefix_i),
    .flag_zero_i  (flag_zero_i),
    .width_i      (width_i),
    .strobe_i     (strobe_o),
    .char_i       (char_out_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // drive one command word and hold it until it is taken
  task automatic send_word(input logic [2:0] act, input logic [ValW-1:0] val,
                           input logic left, input logic sgn, input logic spc,
                           input logic pfx, input logic zro,
                           input logic [CntW-1:0] wid);
    start         <= 1'b1;
    action_i      <= act;
    value_i       <= val;
    flag_left_i   <= left;
    flag_sign_i   <= sgn;
    flag_space_i  <= spc;
    flag_prefix_i <= pfx;
    flag_zero_i   <= zro;
    width_i       <= wid;
    do @(posedge clk_i); while (busy_s);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // hold off until every expected character is out, then let the back end settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0]      act;
    logic [ValW-1:0] val;
    logic [CntW-1:0] wid;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(ActSdec, 32'd0,          0, 0, 0, 0, 0, 7'd0);
    send_word(ActSdec, 32'h8000_0000,  0, 0, 0, 0, 0, 7'd0);
    send_word(ActSdec, 32'h7fff_ffff,  0, 1, 0, 0, 0, 7'd0);
    send_word(ActSdec, 32'd5,          0, 0, 1, 0, 0, 7'd4);
    send_word(ActSdec, -32'sd42,       0, 0, 0, 0, 1, 7'd8);   // '-' ahead of the zeros
    send_word(ActSdec, 32'd7,          0, 1, 1, 0, 0, 7'd3);   // plus wins over space
    send_word(ActSdec, 32'hffff_ffff,  1, 0, 0, 0, 1, 7'd6);   // left wins over zero pad
    send_word(ActUdec, 32'hffff_ffff,  0, 0, 0, 0, 0, 7'd0);
    send_word(ActUdec, 32'd0,          0, 1, 1, 1, 0, 7'd3);   // sign/prefix ignored
    send_word(ActHex,  32'd0,          0, 0, 0, 1, 0, 7'd0);
    send_word(ActHex,  32'hffff_ffff,  0, 0, 0, 1, 1, 7'd12);
    send_word(ActHex,  32'hdead_beef,  1, 1, 1, 0, 0, 7'd12);
    send_word(ActOct,  32'd0,          0, 0, 0, 1, 0, 7'd0);
    send_word(ActOct,  32'hffff_ffff,  0, 0, 0, 1, 0, 7'd1);
    send_word(ActOct,  32'd8,          0, 0, 0, 1, 1, 7'd6);
    send_word(ActChar, 32'h0000_0041,  0, 1, 0, 1, 1, 7'd5);   // char zero-padded too
    send_word(ActChar, 32'hffff_ffff,  1, 0, 0, 0, 0, 7'd3);
    send_word(ActChar, 32'h1234_5600,  0, 0, 0, 0, 0, 7'd0);
    send_word(3'd5,    32'h1234_5678,  0, 0, 0, 0, 0, 7'd0);   // no characters at all
    send_word(3'd6,    32'd0,          0, 0, 0, 0, 1, 7'd4);
    send_word(3'd7,    32'hffff_ffff,  1, 1, 1, 1, 1, 7'd127);
    send_word(ActSdec, 32'd12345,      0, 0, 0, 0, 0, 7'd64);
    send_word(ActUdec, 32'd1,          0, 0, 0, 0, 1, 7'd127);
    send_word(ActHex,  32'h1234,       0, 1, 1, 0, 0, 7'd2);   // width below content
    drain();

    for (int n = 0; n < RandWords; n++) begin
      act = ($urandom_range(0, 99) < 7) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 5))
        0:       val = $urandom_range(0, 20);
        1:       val = -$urandom_range(1, 20);
        2: begin
          case ($urandom_range(0, 4))
            0:       val = 32'h0000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'h8000_0000;
            3:       val = 32'hffff_ffff;
            default: val = 32'h0000_0001;
          endcase
        end
        3:       val = $urandom >> $urandom_range(0, 31);
        default: val = $urandom;
      endcase
      case ($urandom_range(0, 19))
        0:       wid = 7'($urandom_range(65, 127));
        1, 2, 3: wid = 7'($urandom_range(16, 64));
        default: wid = 7'($urandom_range(0, 15));
      endcase
      send_word(act, val, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                1'($urandom), wid);
      if (n == RandWords / 2)
        drain();
      else if (n < 120 || n > 220)
        maybe_idle();
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
